>>> hdl/lrupc_pkg.sv
// lrupc_pkg: shared types and constants for the lru page cache tag lookup block
// used by lru_page_cache_tag_lookup_top and its port checker; no dependencies
package lrupc_pkg;

  localparam int SLOTS       = 32;
  localparam int SLOT_AW     = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int SLOT_IDX_W  = 5;
  localparam int SHARD_W     = 16;
  localparam int OFFSET_W    = 48;
  localparam int PG_SIZE_W   = 25;
  localparam int SLOTS_REG_W = 6;
  localparam int STAMP_W     = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PG_SIZE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = CFG_IDX_W'(1);

  localparam logic [PG_SIZE_W-1:0]   PG_SIZE_RST      = PG_SIZE_W'(65536);
  localparam logic [SLOTS_REG_W-1:0] SLOTS_IN_USE_RST = SLOTS_REG_W'(32);

  typedef struct packed {
    logic [SHARD_W-1:0]   shard_no;
    logic [OFFSET_W-1:0]  pg_offset;
    logic [PG_SIZE_W-1:0] req_pg_size;
  } req_t;

  typedef struct packed {
    logic                  error;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  evicted;
  } rsp_t;

  // one tag memory word: tag plus last use stamp
  typedef struct packed {
    logic [SHARD_W-1:0]  shard;
    logic [OFFSET_W-1:0] offset;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

endpackage

>>> hdl/lru_page_cache_tag_lookup_top.sv
// lru_page_cache_tag_lookup_top: fully associative page cache tag engine with lru replacement
// depends on lrupc_pkg (request/response structs, tag memory word, constants)
// channels
//   in_*  : one request per handshake (shard, page offset, page size)
//   out_* : one response per request (error, hit, slot index, evicted)
//   cfg_* : index 0 = page size, index 1 = slots in use; cfg_ready is always
//           high, write only while the block is idle
// operation
//   a size mismatch returns an error response and changes nothing. otherwise
//   the use clock advances and the tag memory is read one slot per cycle;
//   each word is compared with the request and folded into the victim choice.
//   a hit restamps that slot, a miss installs into the victim after the last
//   slot has been compared
// timing
//   one request at a time: ST_SCAN reads the slots in use (capped at 32) and
//   compares each registered word, ST_DONE holds the result for the output
//   register; an error skips ST_SCAN. the next request is taken once the
//   response sits in the output register, even while out_ready is low
// reset
//   synchronous, active low: slots invalid, use clock zero, registers at defaults
module lru_page_cache_tag_lookup_top
  import lrupc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  req_t                  in_data,
  // response channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output rsp_t                  out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // configuration registers
  logic [PG_SIZE_W-1:0]   pg_size_r;
  logic [SLOTS_REG_W-1:0] slots_in_use_r;

  // sequencer and request context
  logic [1:0]             state_r, state_nxt;
  req_t                   req_r, req_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;       // slots to scan for this request
  logic [CNT_W-1:0]       issue_r, issue_nxt;   // reads issued so far
  logic                   pend_r, pend_nxt;     // read data for cmp_idx_r arrives
  logic [SLOT_AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [STAMP_W-1:0]     clock_r, clock_nxt;
  logic [SLOTS-1:0]       valid_r, valid_nxt;

  // running victim choice
  logic [SLOT_AW-1:0]     vic_idx_r, vic_idx_nxt;
  logic                   vic_valid_r, vic_valid_nxt;
  logic [STAMP_W-1:0]     vic_stamp_r, vic_stamp_nxt;

  // finished result and output register
  rsp_t                   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rsp_t                   out_data_r, out_data_nxt;

  // tag memory, one read and one write port, registered read data
  entry_t                 tag_mem [SLOTS];
  entry_t                 rd_data_r;
  logic                   rd_en;
  logic [SLOT_AW-1:0]     rd_addr;
  logic                   wr_en;
  logic [SLOT_AW-1:0]     wr_addr;
  entry_t                 wr_data;

  // compare-stage terms
  logic                   in_fire;
  logic                   out_load;
  logic                   slot_v;
  logic                   tag_hit;
  logic                   take_vic;
  logic                   miss_done;
  logic [SLOT_AW-1:0]     last_idx;
  logic [SLOT_AW-1:0]     vic_idx_c;
  logic                   vic_valid_c;
  logic [STAMP_W-1:0]     vic_stamp_c;
  logic [CNT_W-1:0]       cnt_sat;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // slots in use saturates at the number of physical slots
  assign cnt_sat = (CNT_W'(slots_in_use_r) > CNT_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                           : CNT_W'(slots_in_use_r);

  // compare the word that came back from the tag memory
  assign slot_v   = valid_r[cmp_idx_r];
  assign tag_hit  = (state_r == ST_SCAN) && pend_r && slot_v &&
                    (rd_data_r.shard == req_r.shard_no) &&
                    (rd_data_r.offset == req_r.pg_offset);
  // slot 0 seeds the choice; later invalid slots win, else strictly older stamps
  assign take_vic = (cmp_idx_r == '0) || !slot_v ||
                    (vic_valid_r && (rd_data_r.stamp < vic_stamp_r));
  assign last_idx = SLOT_AW'(cnt_r - CNT_W'(1));

  always_comb begin
    if (pend_r && take_vic) begin
      vic_idx_c   = cmp_idx_r;
      vic_valid_c = slot_v;
      vic_stamp_c = rd_data_r.stamp;
    end else begin
      vic_idx_c   = vic_idx_r;
      vic_valid_c = vic_valid_r;
      vic_stamp_c = vic_stamp_r;
    end
  end

  // miss is known after the last slot compares, or at once with nothing to scan
  assign miss_done = (state_r == ST_SCAN) && !tag_hit &&
                     ((cnt_r == '0) || (pend_r && (cmp_idx_r == last_idx)));

  // read side: one slot address per cycle
  assign rd_en   = (state_r == ST_SCAN) && (issue_r < cnt_r) && !tag_hit && !miss_done;
  assign rd_addr = issue_r[SLOT_AW-1:0];

  // write side: hit restamps the slot, miss installs into the victim;
  // on a hit the request tag equals the stored one so only the stamp changes
  assign wr_en   = tag_hit || miss_done;
  assign wr_addr = tag_hit ? cmp_idx_r : vic_idx_c;
  assign wr_data = '{shard: req_r.shard_no, offset: req_r.pg_offset, stamp: clock_r};

  // output register takes the result when empty or being drained
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    issue_nxt     = issue_r;
    pend_nxt      = rd_en;
    cmp_idx_nxt   = rd_en ? rd_addr : cmp_idx_r;
    clock_nxt     = clock_r;
    valid_nxt     = valid_r;
    vic_idx_nxt   = vic_idx_c;
    vic_valid_nxt = vic_valid_c;
    vic_stamp_nxt = vic_stamp_c;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt = in_data;
          if (in_data.req_pg_size != pg_size_r) begin
            // size mismatch: report and leave tags, valid bits and use clock alone
            res_nxt   = '{error: 1'b1, hit: 1'b0, slot_index: '0, evicted: 1'b0};
            state_nxt = ST_DONE;
          end else begin
            clock_nxt     = clock_r + STAMP_W'(1);
            cnt_nxt       = cnt_sat;
            issue_nxt     = '0;
            vic_idx_nxt   = '0;
            vic_valid_nxt = valid_r[0];
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (tag_hit) begin
          res_nxt   = '{error: 1'b0, hit: 1'b1,
                        slot_index: SLOT_IDX_W'(cmp_idx_r), evicted: 1'b0};
          state_nxt = ST_DONE;
        end else if (miss_done) begin
          valid_nxt[vic_idx_c] = 1'b1;
          res_nxt   = '{error: 1'b0, hit: 1'b0,
                        slot_index: SLOT_IDX_W'(vic_idx_c), evicted: vic_valid_c};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      pend_r         <= 1'b0;
      clock_r        <= '0;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
      pg_size_r      <= PG_SIZE_RST;
      slots_in_use_r <= SLOTS_IN_USE_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      clock_r     <= clock_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PG_SIZE:      pg_size_r      <= cfg_data[PG_SIZE_W-1:0];
          CFG_SLOTS_IN_USE: slots_in_use_r <= cfg_data[SLOTS_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    cnt_r       <= cnt_nxt;
    issue_r     <= issue_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_valid_r <= vic_valid_nxt;
    vic_stamp_r <= vic_stamp_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= tag_mem[rd_addr];
    end
  end

endmodule

>>> hdl/lrupc_port_checker.sv
// lrupc_port_checker: port-level assertions for lru_page_cache_tag_lookup_top
// depends on lrupc_pkg; bound to the top level at the end of this file
module lrupc_port_checker
  import lrupc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // one request in flight: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // an error response carries no lookup result
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |->
      !out_data.hit && !out_data.evicted && (out_data.slot_index == '0))
    else $error("error response with lookup fields set");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.evicted))
    else $error("hit reported with eviction");

endmodule

bind lru_page_cache_tag_lookup_top lrupc_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
